>>> hdl/sorted_event_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted event queue assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_QUEUE_UNIT_MACROS_SVH
`define SORTED_EVENT_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define SEQ_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sorted event queue: check failed");

// ant at an edge implies cons at the same edge
`define SEQ_ASSERT_IMPLY(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("sorted event queue: implication failed");

// ant at an edge implies cons at the next edge
`define SEQ_ASSERT_NEXT(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("sorted event queue: next-cycle check failed");

`else

`define SEQ_ASSERT_ALWAYS(label, clk, rst, expr)
`define SEQ_ASSERT_IMPLY(label, clk, rst, ant, cons)
`define SEQ_ASSERT_NEXT(label, clk, rst, ant, cons)

`endif

`endif

>>> hdl/seq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted event queue package
// Command codes and the sequencer state type shared by the queue files.
// ----------------------------------------------------------------------------
package seq_pkg;

   // command field of a request word
   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_INSERT    = 2'd0;
   localparam cmd_type CMD_REMOVE_ID = 2'd1;
   localparam cmd_type CMD_POP       = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

endpackage

>>> hdl/seq_req_if.sv
// ----------------------------------------------------------------------------
// Sorted event queue request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface seq_req_if #(
   parameter int ID_BITS   = 8,
   parameter int TIME_BITS = 32
);
   logic                 valid;
   logic                 ready;
   seq_pkg::cmd_type     command;
   logic [ID_BITS-1:0]   process_id;
   logic [TIME_BITS-1:0] event_time;
   logic                 tie_before;

   modport source (
      output valid, command, process_id, event_time, tie_before,
      input  ready
   );

   modport sink (
      input  valid, command, process_id, event_time, tie_before,
      output ready
   );
endinterface

>>> hdl/seq_rsp_if.sv
// ----------------------------------------------------------------------------
// Sorted event queue response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface seq_rsp_if #(
   parameter int ID_BITS    = 8,
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 5
);
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [ID_BITS-1:0]    removed_id;
   logic [TIME_BITS-1:0]  removed_time;
   logic                  overflow;
   logic [COUNT_BITS-1:0] entries_held;

   modport source (
      output valid, found, removed_id, removed_time, overflow, entries_held,
      input  ready
   );

   modport sink (
      input  valid, found, removed_id, removed_time, overflow, entries_held,
      output ready
   );
endinterface

>>> hdl/sorted_event_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted event queue unit
// Time-ordered list of (process id, event time) entries held in one RAM.
// ----------------------------------------------------------------------------
// The list lives in a single RAM with one write port and one registered read
// port; a sequencer walks it one entry at a time. An insert starts at the
// tail and moves entries up by one slot until it finds its place, reading
// every entry it moves and, unless the new entry lands at the head, the one
// entry that stops the walk. A remove by id or a pop scans from the head, one
// entry read per step, and then moves the entries behind the hit down by one;
// a pop thus takes the head entry and moves every other entry down. A remove
// or pop on an empty list, an insert on a full list and an unused command go
// straight to the done state. The RAM read-to-write round trip per entry
// sets the pace of the walk. A new request word is taken as soon as the
// sequencer is idle, even while the previous result word still waits in the
// output register. The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "sorted_event_queue_unit_macros.svh"

module sorted_event_queue_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   parameter int TIME_BITS   = 32
) (
   input logic      clock,
   input logic      reset,
   seq_req_if.sink  req_chan,
   seq_rsp_if.source rsp_chan
);

   localparam int AddrBits  = $clog2(QUEUE_DEPTH);
   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
   localparam int EntryBits = ID_BITS + TIME_BITS;

   localparam logic [CountBits-1:0] DepthCount = CountBits'(QUEUE_DEPTH);
   localparam logic [CountBits-1:0] ZeroCount  = CountBits'(0);
   localparam logic [CountBits-1:0] OneCount   = CountBits'(1);
   localparam logic [CountBits-1:0] TwoCount   = CountBits'(2);

   // sequencer and operand registers
   seq_pkg::state_type   state_ff, state_in;
   seq_pkg::cmd_type     cmd_ff, cmd_in;
   logic [ID_BITS-1:0]   key_id_ff, key_id_in;
   logic [TIME_BITS-1:0] key_time_ff, key_time_in;
   logic                 tie_ff, tie_in;
   logic [CountBits-1:0] pos_ff, pos_in;
   logic [CountBits-1:0] fill_ff, fill_in;

   // result being built
   logic                 found_ff, found_in;
   logic [ID_BITS-1:0]   rid_ff, rid_in;
   logic [TIME_BITS-1:0] rtm_ff, rtm_in;
   logic                 ovf_ff, ovf_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic [TIME_BITS-1:0] rsp_time_ff, rsp_time_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic [CountBits-1:0] rsp_held_ff, rsp_held_in;

   // entry RAM
   logic [EntryBits-1:0] mem [QUEUE_DEPTH];
   logic [EntryBits-1:0] rd_data_ff;
   logic                 mem_we;
   logic [AddrBits-1:0]  mem_waddr;
   logic [EntryBits-1:0] mem_wdata;
   logic [AddrBits-1:0]  mem_raddr;

   // decode
   logic                 accept;
   logic                 rsp_free;
   logic [TIME_BITS-1:0] rd_time;
   logic [ID_BITS-1:0]   rd_id;
   logic                 later;
   logic                 hit;
   logic [CountBits-1:0] pos_next;
   logic [CountBits-1:0] pos_prev;
   logic [CountBits-1:0] pos_next2;
   logic                 scan_last;
   logic                 shift_last;

   assign accept    = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign rd_time   = rd_data_ff[TIME_BITS-1:0];
   assign rd_id     = rd_data_ff[EntryBits-1:TIME_BITS];
   // stored entry goes behind the new one
   assign later     = tie_ff ? (rd_time >= key_time_ff) : (rd_time > key_time_ff);
   assign hit       = (cmd_ff == seq_pkg::CMD_POP) || (rd_id == key_id_ff);
   assign pos_next  = pos_ff + OneCount;
   assign pos_prev  = pos_ff - OneCount;
   assign pos_next2 = pos_ff + TwoCount;
   assign scan_last  = pos_next >= fill_ff;
   assign shift_last = pos_next2 >= fill_ff;

   assign req_chan.ready = (state_ff == seq_pkg::ST_IDLE);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.removed_id   = rsp_id_ff;
   assign rsp_chan.removed_time = rsp_time_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;
   assign rsp_chan.entries_held = rsp_held_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         seq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_chan.command)
                  seq_pkg::CMD_INSERT: begin
                     if (fill_ff == DepthCount) state_in = seq_pkg::ST_DONE;
                     else if (fill_ff == ZeroCount) state_in = seq_pkg::ST_INS_PUT;
                     else state_in = seq_pkg::ST_INS_RD;
                  end
                  seq_pkg::CMD_REMOVE_ID,
                  seq_pkg::CMD_POP: begin
                     if (fill_ff == ZeroCount) state_in = seq_pkg::ST_DONE;
                     else state_in = seq_pkg::ST_SRCH_RD;
                  end
                  default: state_in = seq_pkg::ST_DONE;
               endcase
            end
         end
         seq_pkg::ST_INS_RD: state_in = seq_pkg::ST_INS_CMP;
         seq_pkg::ST_INS_CMP: begin
            if (later && (pos_ff != OneCount)) state_in = seq_pkg::ST_INS_RD;
            else state_in = seq_pkg::ST_INS_PUT;
         end
         seq_pkg::ST_INS_PUT: state_in = seq_pkg::ST_DONE;
         seq_pkg::ST_SRCH_RD: state_in = seq_pkg::ST_SRCH_CMP;
         seq_pkg::ST_SRCH_CMP: begin
            if (scan_last) state_in = seq_pkg::ST_DONE;
            else if (hit) state_in = seq_pkg::ST_SHIFT_RD;
            else state_in = seq_pkg::ST_SRCH_RD;
         end
         seq_pkg::ST_SHIFT_RD: state_in = seq_pkg::ST_SHIFT_WR;
         seq_pkg::ST_SHIFT_WR: begin
            if (shift_last) state_in = seq_pkg::ST_DONE;
            else state_in = seq_pkg::ST_SHIFT_RD;
         end
         seq_pkg::ST_DONE: begin
            if (rsp_free) state_in = seq_pkg::ST_IDLE;
         end
         default: state_in = seq_pkg::ST_IDLE;
      endcase
   end

   // datapath, RAM control and result word
   always_comb begin
      cmd_in      = cmd_ff;
      key_id_in   = key_id_ff;
      key_time_in = key_time_ff;
      tie_in      = tie_ff;
      pos_in      = pos_ff;
      fill_in     = fill_ff;
      found_in    = found_ff;
      rid_in      = rid_ff;
      rtm_in      = rtm_ff;
      ovf_in      = ovf_ff;
      mem_we      = 1'b0;
      mem_waddr   = pos_ff[AddrBits-1:0];
      mem_wdata   = rd_data_ff;
      mem_raddr   = pos_ff[AddrBits-1:0];

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_held_in  = rsp_held_ff;

      case (state_ff)
         seq_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_chan.command;
               key_id_in   = req_chan.process_id;
               key_time_in = req_chan.event_time;
               tie_in      = req_chan.tie_before;
               found_in    = 1'b0;
               rid_in      = '0;
               rtm_in      = '0;
               ovf_in      = (req_chan.command == seq_pkg::CMD_INSERT) &&
                             (fill_ff == DepthCount);
               pos_in      = (req_chan.command == seq_pkg::CMD_INSERT) ? fill_ff : ZeroCount;
            end
         end
         // read the entry just below the insert point
         seq_pkg::ST_INS_RD: begin
            mem_raddr = pos_prev[AddrBits-1:0];
         end
         // move it up one slot when it sorts after the new entry
         seq_pkg::ST_INS_CMP: begin
            if (later) begin
               mem_we = 1'b1;
               pos_in = pos_prev;
            end
         end
         seq_pkg::ST_INS_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = {key_id_ff, key_time_ff};
            fill_in   = fill_ff + OneCount;
         end
         seq_pkg::ST_SRCH_RD: begin
            mem_raddr = pos_ff[AddrBits-1:0];
         end
         // first match from the head wins
         seq_pkg::ST_SRCH_CMP: begin
            if (hit) begin
               found_in = 1'b1;
               rid_in   = rd_id;
               rtm_in   = rd_time;
               if (scan_last) fill_in = fill_ff - OneCount;
            end else begin
               pos_in = pos_next;
            end
         end
         // close the gap: slot pos takes slot pos + 1
         seq_pkg::ST_SHIFT_RD: begin
            mem_raddr = pos_next[AddrBits-1:0];
         end
         seq_pkg::ST_SHIFT_WR: begin
            mem_we = 1'b1;
            pos_in = pos_next;
            if (shift_last) fill_in = fill_ff - OneCount;
         end
         seq_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_id_in    = rid_ff;
               rsp_time_in  = rtm_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_held_in  = fill_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // entry RAM, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= seq_pkg::ST_IDLE;
         fill_ff      <= ZeroCount;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_id_ff    <= key_id_in;
      key_time_ff  <= key_time_in;
      tie_ff       <= tie_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      rid_ff       <= rid_in;
      rtm_ff       <= rtm_in;
      ovf_ff       <= ovf_in;
      rsp_found_ff <= rsp_found_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_held_ff  <= rsp_held_in;
   end

   // checks
   `SEQ_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= DepthCount)
   `SEQ_ASSERT_IMPLY(a_found_ovf_excl, clock, reset, rsp_valid_ff,
                     !(rsp_found_ff && rsp_ovf_ff))
   `SEQ_ASSERT_IMPLY(a_ovf_full, clock, reset, rsp_valid_ff && rsp_ovf_ff,
                     rsp_held_ff == DepthCount)
   `SEQ_ASSERT_IMPLY(a_scan_in_list, clock, reset,
                     (state_ff == seq_pkg::ST_SRCH_CMP) || (state_ff == seq_pkg::ST_SHIFT_WR),
                     pos_ff < fill_ff)
   `SEQ_ASSERT_NEXT(a_done_loads, clock, reset, (state_ff == seq_pkg::ST_DONE) && rsp_free,
                    rsp_valid_ff && (state_ff == seq_pkg::ST_IDLE))

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted event queue testbench
// Drives insert, remove-by-id, pop and unused command words through the
// request channel with bursty timing, keeps a shadow of the time-ordered
// list to predict each result word, and checks every result word field by
// field while the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int ID_W        = 8;
   localparam int TIME_W      = 32;
   localparam int COUNT_W     = 5;
   localparam int RANDOM_WORDS = 1750;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 50;

   // the fourth command code is not defined by the package; it is a no-op
   localparam seq_pkg::cmd_type CMD_UNUSED = 2'd3;

   typedef struct {
      seq_pkg::cmd_type  cmd;
      logic [ID_W-1:0]   pid;
      logic [TIME_W-1:0] etime;
      logic              tie;
      bit                wait_empty;   // hold this word until the queue drains
   } request_word_type;

   typedef struct packed {
      logic               found;
      logic [ID_W-1:0]    removed_id;
      logic [TIME_W-1:0]  removed_time;
      logic               overflow;
      logic [COUNT_W-1:0] entries_held;
   } queue_outcome_type;

   logic clock;
   logic reset;

   seq_req_if #(.ID_BITS(ID_W), .TIME_BITS(TIME_W)) req_bus ();
   seq_rsp_if #(.ID_BITS(ID_W), .TIME_BITS(TIME_W), .COUNT_BITS(COUNT_W)) rsp_bus ();

   sorted_event_queue_unit #(
      .QUEUE_DEPTH(DEPTH),
      .ID_BITS    (ID_W),
      .TIME_BITS  (TIME_W)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // shadow of the event list, head at index 0
   logic [ID_W-1:0]   shadow_id   [DEPTH];
   logic [TIME_W-1:0] shadow_time [DEPTH];
   int                shadow_len;

   request_word_type  request_words[$];
   queue_outcome_type expected_results[$];
   int             outstanding;     // copy of expected_results.size(), updated at the edge
   int             error_count;
   int             cycle_count;

   // tallies for the summary
   int n_words, n_inserts, n_dropped, n_taken, n_missed, n_unused;

   // driver state
   int burst_left, gap_left;

   // receiver state
   int results_taken, hold_left, mode_left, ready_mode, pattern_ctr;
   bit long_hold_done;

   // clock and known input levels from time zero
   initial begin
      clock = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.command    = seq_pkg::CMD_INSERT;
      req_bus.process_id = '0;
      req_bus.event_time = '0;
      req_bus.tie_before = 1'b0;
      rsp_bus.ready      = 1'b0;
      forever #5 clock = ~clock;
   end

   // unlink the entry at pos and close the gap behind it
   function automatic void unlink_entry(int pos, ref queue_outcome_type res);
      int k;
      res.found        = 1'b1;
      res.removed_id   = shadow_id[pos];
      res.removed_time = shadow_time[pos];
      for (k = pos; k + 1 < shadow_len; k++) begin
         shadow_id[k]   = shadow_id[k + 1];
         shadow_time[k] = shadow_time[k + 1];
      end
      shadow_len--;
   endfunction

   // apply one command word to the shadow list, return the result word
   function automatic queue_outcome_type schedule_step(seq_pkg::cmd_type cmd,
                                                       logic [ID_W-1:0] pid,
                                                       logic [TIME_W-1:0] etime,
                                                       logic tie);
      queue_outcome_type res;
      int pos;
      int k;
      bit hit;
      res = '0;
      hit = 1'b0;
      case (cmd)
         seq_pkg::CMD_INSERT: begin
            if (shadow_len >= DEPTH) begin
               res.overflow = 1'b1;
            end else begin
               pos = shadow_len;
               for (k = 0; k < shadow_len && !hit; k++) begin
                  if (tie ? (shadow_time[k] >= etime) : (shadow_time[k] > etime)) begin
                     pos = k;
                     hit = 1'b1;
                  end
               end
               for (k = shadow_len; k > pos; k--) begin
                  shadow_id[k]   = shadow_id[k - 1];
                  shadow_time[k] = shadow_time[k - 1];
               end
               shadow_id[pos]   = pid;
               shadow_time[pos] = etime;
               shadow_len++;
            end
         end
         seq_pkg::CMD_REMOVE_ID: begin
            // only the match nearest the head goes
            for (k = 0; k < shadow_len && !hit; k++) begin
               if (shadow_id[k] == pid) begin
                  unlink_entry(k, res);
                  hit = 1'b1;
               end
            end
         end
         seq_pkg::CMD_POP: begin
            if (shadow_len > 0) unlink_entry(0, res);
         end
         default: begin
         end
      endcase
      res.entries_held = COUNT_W'(shadow_len);
      return res;
   endfunction

   task automatic add_word(seq_pkg::cmd_type cmd, logic [ID_W-1:0] pid,
                           logic [TIME_W-1:0] etime, logic tie, bit wait_empty);
      request_word_type w;
      w.cmd        = cmd;
      w.pid        = pid;
      w.etime      = etime;
      w.tie        = tie;
      w.wait_empty = wait_empty;
      request_words.push_back(w);
   endtask

   // ids: mostly a small pool so removes hit and duplicates occur
   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 75) return ID_W'($urandom_range(15));
      if (r < 90) return ID_W'($urandom);
      return (r < 95) ? '0 : '1;
   endfunction

   // times: narrow range for ties, full range, and the extremes
   function automatic logic [TIME_W-1:0] pick_time();
      int r;
      r = $urandom_range(99);
      if (r < 40) return TIME_W'($urandom_range(15));
      if (r < 80) return TIME_W'($urandom);
      if (r < 85) return '0;
      if (r < 90) return '1;
      return '1 - TIME_W'($urandom_range(15));
   endfunction

   // stimulus, reset and end of run
   initial begin
      int k, r, phase_left, p_insert;
      seq_pkg::cmd_type c;

      // empty list, unused code, extremes, ties both ways, duplicate ids
      add_word(seq_pkg::CMD_POP,       8'h00, 32'h0, 1'b0, 1'b0);
      add_word(seq_pkg::CMD_REMOVE_ID, 8'h12, 32'h0, 1'b0, 1'b0);
      add_word(CMD_UNUSED,             8'hff, '1,    1'b1, 1'b0);
      add_word(seq_pkg::CMD_INSERT,    8'h00, 32'h0, 1'b0, 1'b0);
      add_word(seq_pkg::CMD_INSERT,    8'hff, '1,    1'b1, 1'b0);
      add_word(seq_pkg::CMD_INSERT,    8'h55, 32'd100, 1'b0, 1'b0);
      add_word(seq_pkg::CMD_INSERT,    8'haa, 32'd100, 1'b1, 1'b0);
      add_word(seq_pkg::CMD_INSERT,    8'h33, 32'd100, 1'b0, 1'b0);
      add_word(seq_pkg::CMD_INSERT,    8'h55, 32'd50,  1'b0, 1'b0);
      add_word(seq_pkg::CMD_REMOVE_ID, 8'h55, 32'h0, 1'b0, 1'b0);
      add_word(seq_pkg::CMD_REMOVE_ID, 8'h77, 32'h0, 1'b0, 1'b0);
      add_word(seq_pkg::CMD_POP,       8'h00, 32'h0, 1'b0, 1'b0);
      // fill to the top, then one insert too many
      for (k = 0; k < DEPTH - 3; k++)
         add_word(seq_pkg::CMD_INSERT, ID_W'(k), TIME_W'($urandom_range(1000)), k[0], 1'b0);

      // random part: alternating fill and drain phases so the level sweeps
      phase_left = 0;
      p_insert = 50;
      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            p_insert = (p_insert > 50) ? $urandom_range(20, 35) : $urandom_range(65, 80);
         end
         phase_left--;
         r = $urandom_range(99);
         if (r < p_insert) c = seq_pkg::CMD_INSERT;
         else if (r < 98 - (98 - p_insert) / 2) c = seq_pkg::CMD_REMOVE_ID;
         else if (r < 98) c = seq_pkg::CMD_POP;
         else c = CMD_UNUSED;
         add_word(c, pick_id(), pick_time(), 1'($urandom_range(1)),
                  (k == 0 || k == 600 || k == 1200));
      end

      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (request_words.size() != 0 || outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, expected_results.size());
         error_count++;
      end
      $display("Checked %0d words: %0d inserts (%0d dropped on a full list), %0d unused codes.",
               n_words, n_inserts, n_dropped, n_unused);
      $display("Removes and pops: %0d took an entry out, %0d found nothing.",
               n_taken, n_missed);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // request driver: bursts with random gaps, optional drain before a word
   always @(posedge clock) begin
      bit take;
      bit offer;
      take  = req_bus.valid && req_bus.ready;
      offer = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (take) void'(request_words.pop_front());
         if (req_bus.valid && !take) begin
            offer = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (request_words.size() != 0 &&
                      !(request_words[0].wait_empty && (outstanding != 0 || take))) begin
            offer = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = $urandom_range(1) ? 0 : $urandom_range(1, 10);
            end
         end
         req_bus.valid <= offer;
         if (offer) begin
            req_bus.command    <= request_words[0].cmd;
            req_bus.process_id <= request_words[0].pid;
            req_bus.event_time <= request_words[0].etime;
            req_bus.tie_before <= request_words[0].tie;
         end
      end
   end

   // response ready: pattern modes plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         results_taken  = 0;
         hold_left      = 0;
         mode_left      = 0;
         ready_mode     = 0;
         pattern_ctr    = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) results_taken++;
         if (results_taken == 300 && !long_hold_done) begin
            hold_left      = 250;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(3);
               mode_left  = $urandom_range(20, 120);
            end else begin
               mode_left--;
            end
            pattern_ctr++;
            case (ready_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(1));
               2: rsp_bus.ready <= ($urandom_range(3) != 0);
               default: rsp_bus.ready <= (pattern_ctr % 4 == 0);
            endcase
         end
      end
   end

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor: checks result words, predicts on accepted request words
   always @(posedge clock) begin
      queue_outcome_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result word, actual id %0h time %0h", $time,
                        rsp_bus.removed_id, rsp_bus.removed_time);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("found", 32'(want.found), 32'(rsp_bus.found));
               compare_field("removed_id", 32'(want.removed_id), 32'(rsp_bus.removed_id));
               compare_field("removed_time", want.removed_time, rsp_bus.removed_time);
               compare_field("overflow", 32'(want.overflow), 32'(rsp_bus.overflow));
               compare_field("entries_held", 32'(want.entries_held),
                             32'(rsp_bus.entries_held));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = schedule_step(req_bus.command, req_bus.process_id,
                                 req_bus.event_time, req_bus.tie_before);
            n_words++;
            if (req_bus.command == seq_pkg::CMD_INSERT) begin
               n_inserts++;
               if (want.overflow) n_dropped++;
            end else if (req_bus.command == CMD_UNUSED) begin
               n_unused++;
            end else if (want.found) begin
               n_taken++;
            end else begin
               n_missed++;
            end
            expected_results.push_back(want);
         end
         outstanding <= expected_results.size();
      end else begin
         shadow_len  = 0;
         outstanding <= 0;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      shadow_len  = 0;
      outstanding = 0;
      error_count = 0;
      cycle_count = 0;
      n_words = 0; n_inserts = 0; n_dropped = 0;
      n_taken = 0; n_missed = 0; n_unused = 0;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/seq_pkg.sv
hdl/seq_req_if.sv
hdl/seq_rsp_if.sv
hdl/sorted_event_queue_unit.sv
verif/tb_top.sv
